FILE: hdl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/dthp_pkg.sv
package dthp_pkg;

    localparam int unsigned DoubleW   = 64;
    localparam int unsigned FracW     = 52;
    localparam int unsigned ExpW      = 11;
    localparam int unsigned HalfW     = 16;
    localparam logic [ExpW-1:0] ExpMax = 11'h7FF;
    // Biased exponent bounds: 1023+16 overflows, below 1023-25 flushes.
    localparam logic [ExpW-1:0] ExpOvf   = 11'd1039;
    localparam logic [ExpW-1:0] ExpTiny  = 11'd998;
    localparam logic [ExpW-1:0] ExpNorm  = 11'd1009;
    localparam logic [HalfW-1:0] HalfInf = 16'h7C00;
    localparam logic [HalfW-1:0] HalfNan = 16'h7E00;

    localparam logic BoBig    = 1'b0;
    localparam logic BoLittle = 1'b1;

    // Classification carried from the decode stage.
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_SPEC = 2'd1,
        K_OVF  = 2'd2,
        K_NUM  = 2'd3
    } t_kind;

    typedef struct packed {
        logic              sign;
        t_kind             kind;
        logic [HalfW-1:0]  spec;
        logic [5:0]        sh;
        logic [4:0]        hexp;
        logic              norm;
        logic [FracW:0]    sig;
    } t_dec;

    typedef struct packed {
        logic              sign;
        t_kind             kind;
        logic [HalfW-1:0]  spec;
        logic [4:0]        hexp;
        logic              norm;
        logic [11:0]       q;
        logic              rnd_up;
    } t_rnd;

endpackage

FILE: hdl/dthp_decode.sv
module dthp_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [dthp_pkg::DoubleW-1:0]    i_bits,
    output logic                            o_valid,
    output dthp_pkg::t_dec                  o_dec
);

    logic            r_valid;
    dthp_pkg::t_dec  r_dec;
    dthp_pkg::t_dec  n_dec;
    logic [10:0]     bexp;

    always_comb begin
        bexp        = i_bits[62:52];
        n_dec       = '0;
        n_dec.sign  = i_bits[63];
        n_dec.sig   = {1'b1, i_bits[51:0]};
        n_dec.norm  = (bexp >= dthp_pkg::ExpNorm);
        // Half exponent field e+15 for normal results.
        n_dec.hexp  = 5'(bexp - 11'd1008);
        // Shift 42 for normal, 28-e = 1051-bexp for subnormal (43..53).
        n_dec.sh    = n_dec.norm ? 6'd42 : 6'(11'd1051 - bexp);
        if (bexp == dthp_pkg::ExpMax) begin
            n_dec.kind = dthp_pkg::K_SPEC;
            n_dec.spec = (i_bits[51:0] != '0) ? dthp_pkg::HalfNan : dthp_pkg::HalfInf;
        end else if (bexp >= dthp_pkg::ExpOvf) begin
            n_dec.kind = dthp_pkg::K_OVF;
        end else if (bexp < dthp_pkg::ExpTiny) begin
            n_dec.kind = dthp_pkg::K_ZERO;
        end else begin
            n_dec.kind = dthp_pkg::K_NUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

FILE: hdl/dthp_round.sv
module dthp_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dthp_pkg::t_dec  i_dec,
    output logic            o_valid,
    output dthp_pkg::t_rnd  o_rnd
);

    logic            r_valid;
    dthp_pkg::t_rnd  r_rnd;
    dthp_pkg::t_rnd  n_rnd;
    logic [52:0]     q_full;
    logic [52:0]     mask;
    logic [52:0]     rem;
    logic [52:0]     halfway;

    always_comb begin
        q_full  = i_dec.sig >> i_dec.sh;
        mask    = (53'd1 << i_dec.sh) - 53'd1;
        rem     = i_dec.sig & mask;
        halfway = 53'd1 << (i_dec.sh - 6'd1);
        n_rnd        = '0;
        n_rnd.sign   = i_dec.sign;
        n_rnd.kind   = i_dec.kind;
        n_rnd.spec   = i_dec.spec;
        n_rnd.hexp   = i_dec.hexp;
        n_rnd.norm   = i_dec.norm;
        n_rnd.q      = q_full[11:0];
        n_rnd.rnd_up = (rem > halfway) || ((rem == halfway) && q_full[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rnd <= n_rnd;
    end

    assign o_valid = r_valid;
    assign o_rnd   = r_rnd;

endmodule

FILE: hdl/dthp_pack.sv
module dthp_pack (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dthp_pkg::t_rnd  i_rnd,
    input  logic            i_byte_order,
    output logic            o_valid,
    output logic [7:0]      o_first_byte,
    output logic [7:0]      o_second_byte,
    output logic            o_status
);

    logic        r_valid;
    logic [7:0]  r_first;
    logic [7:0]  r_second;
    logic        r_status;
    logic [7:0]  n_first;
    logic [7:0]  n_second;
    logic        n_status;
    logic [12:0] q_inc;
    logic [15:0] val;
    logic [15:0] half;

    always_comb begin
        q_inc = {1'b0, i_rnd.q} + {12'd0, i_rnd.rnd_up};
        // Adding the rounded significand lets a carry bump the exponent.
        if (i_rnd.norm) begin
            val = ({6'd0, i_rnd.hexp, 5'd0} << 5) + {3'd0, q_inc} - 16'd1024;
        end else begin
            val = {3'd0, q_inc};
        end
        half     = '0;
        n_status = 1'b0;
        case (i_rnd.kind)
            dthp_pkg::K_ZERO: half = {i_rnd.sign, 15'd0};
            dthp_pkg::K_SPEC: half = {i_rnd.sign, i_rnd.spec[14:0]};
            dthp_pkg::K_OVF:  n_status = 1'b1;
            default: begin
                if (val >= dthp_pkg::HalfInf) begin
                    n_status = 1'b1;
                end else begin
                    half = {i_rnd.sign, val[14:0]};
                end
            end
        endcase
        if (n_status) begin
            n_first  = '0;
            n_second = '0;
        end else if (i_byte_order == dthp_pkg::BoLittle) begin
            n_first  = half[7:0];
            n_second = half[15:8];
        end else begin
            n_first  = half[15:8];
            n_second = half[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_first  <= n_first;
        r_second <= n_second;
        r_status <= n_status;
    end

    assign o_valid       = r_valid;
    assign o_first_byte  = r_first;
    assign o_second_byte = r_second;
    assign o_status      = r_status;

endmodule

FILE: hdl/double_to_half_pack.sv
// Binary64 to binary16 packer with round to nearest, ties to even.
// Input channel: a transaction is accepted on a rising edge where i_start is
// high and o_busy is low. o_busy is always low, so a new value may enter in
// every cycle. i_double_bits carries the raw binary64 pattern.
// Output channel: each result appears for exactly one cycle with o_done high,
// in input order after the three register stages. The receiver cannot stall.
// Throughput is one transaction per cycle; the stages are decode, significand
// rounding, and exponent/byte packing.
// o_first_byte and o_second_byte hold the half in the byte order chosen by
// the byte_order register (0 big-endian, 1 little-endian); o_status is 1 on
// overflow, with both bytes zero. NaNs become a quiet NaN with sign kept.
// The user writes the configuration register (i_cfg_we/i_cfg_wdata) only
// while no transaction is in flight; the block does not check. Synchronous
// active-low reset clears pipeline valid bits, sets byte_order to big-endian.
`include "assert_macros.svh"

module double_to_half_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [dthp_pkg::DoubleW-1:0]  i_double_bits,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    output logic                          o_done,
    output logic [7:0]                    o_first_byte,
    output logic [7:0]                    o_second_byte,
    output logic                          o_status
);

    logic            r_byte_order;
    logic            dec_valid;
    dthp_pkg::t_dec  dec;
    logic            rnd_valid;
    dthp_pkg::t_rnd  rnd;
    logic            accept;

    // The pipeline never stalls, so the block is never busy.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= dthp_pkg::BoBig;
        end else if (i_cfg_we) begin
            r_byte_order <= i_cfg_wdata;
        end
    end

    dthp_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_bits  (i_double_bits),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    dthp_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .i_dec   (dec),
        .o_valid (rnd_valid),
        .o_rnd   (rnd)
    );

    dthp_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (rnd_valid),
        .i_rnd         (rnd),
        .i_byte_order  (r_byte_order),
        .o_valid       (o_done),
        .o_first_byte  (o_first_byte),
        .o_second_byte (o_second_byte),
        .o_status      (o_status)
    );

    // Every accepted transaction comes out on o_done after the three register stages.
    `ASSERT_CLK(a_latency, i_clk, i_rst_n, accept |-> ##3 o_done, "result lost")
    // Overflow results always carry zero bytes.
    `ASSERT_CLK(a_ovf_zero, i_clk, i_rst_n,
        (o_done && o_status) |-> (o_first_byte == 8'd0 && o_second_byte == 8'd0),
        "overflow with nonzero bytes")
    // No result appears without an earlier accepted transaction.
    `ASSERT_CLK(a_no_spur, i_clk, i_rst_n, o_done |-> $past(accept, 3), "spurious result")

endmodule
